// ===== rtl/core/ndt_pkg.sv =====
// Shared types and constants of the name directory table.
`default_nettype none

package ndt_pkg;

  localparam int unsigned SECTOR_W = 10;
  localparam int unsigned TYPE_W   = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SIZE_W   = 5;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 5'd10;

  // Operation codes; the unused code behaves as a lookup.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Configuration register indexes.
  localparam int unsigned REG_TABLE_SIZE = 0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // Control from the sequencer to the entry store.
  typedef struct packed {
    logic rd_en;   // read the entry and its valid mark
    logic wr_en;   // write the entry and set its valid mark
    logic vclr;    // clear the valid mark of the write address
  } store_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ndt_canon.sv =====
// Name canonicalizer: cuts a name at its first zero byte and at the name length.
`default_nettype none

module ndt_canon #(
  parameter int unsigned NAME_BYTES = 9
) (
  input  wire logic [63:0]             name_low,
  input  wire logic [7:0]              name_high,
  output logic      [NAME_BYTES*8-1:0] name_canon
);

  logic [71:0] all_bytes;

  assign all_bytes = {name_high, name_low};

  always_comb begin
    logic [7:0] b;
    logic       alive;
    alive      = 1'b1;
    name_canon = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      b = all_bytes[8*i +: 8];
      if (b == 8'd0) begin
        alive = 1'b0;
      end
      name_canon[8*i +: 8] = alive ? b : 8'd0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ndt_store.sv =====
// Entry store: synchronous entry memory plus the valid marks of every slot.
`default_nettype none

module ndt_store #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned DATA_W      = 85
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ndt_pkg::store_ctrl_t           ctrl,
  input  wire logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
  input  wire logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]              wr_data,
  output logic                                rd_valid,
  output logic      [DATA_W-1:0]              rd_data
);

  import ndt_pkg::*;

  logic [DATA_W-1:0]      mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctrl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (ctrl.vclr) begin
        valid_r[wr_addr] <= 1'b0;
      end
      if (ctrl.rd_en) begin
        rd_valid <= valid_r[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ndt_ctrl.sv =====
// Sequencer: scans the slots in use, then applies the operation and forms the result.
`default_nettype none

module ndt_ctrl #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned NAME_W      = 72
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ndt_pkg::OP_W-1:0]          in_op,
  input  wire logic [NAME_W-1:0]                 in_name,
  input  wire logic [ndt_pkg::SECTOR_W-1:0]      in_sector,
  input  wire logic [ndt_pkg::TYPE_W-1:0]        in_type,
  input  wire logic [ndt_pkg::SIZE_W-1:0]        table_size,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [ndt_pkg::STATUS_W-1:0]      out_status,
  output logic      [ndt_pkg::SLOT_W-1:0]        out_slot,
  output logic      [ndt_pkg::SECTOR_W-1:0]      out_sector,
  output logic      [ndt_pkg::TYPE_W-1:0]        out_type,
  output logic                                   out_empty,
  output ndt_pkg::store_ctrl_t                   st_ctrl,
  output logic      [$clog2(MAX_ENTRIES)-1:0]    st_rd_addr,
  output logic      [$clog2(MAX_ENTRIES)-1:0]    st_wr_addr,
  output logic      [NAME_W+ndt_pkg::SECTOR_W+ndt_pkg::TYPE_W-1:0] st_wr_data,
  input  wire logic                              st_rd_valid,
  input  wire logic [NAME_W+ndt_pkg::SECTOR_W+ndt_pkg::TYPE_W-1:0] st_rd_data
);

  import ndt_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SZ_W   = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int unsigned EXT_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int unsigned DATA_W = NAME_W + SECTOR_W + TYPE_W;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]     op_r, op_nxt;
  logic [NAME_W-1:0]   name_r, name_nxt;
  logic [SECTOR_W-1:0] sec_r, sec_nxt;
  logic [TYPE_W-1:0]   typ_r, typ_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic                free_r, free_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]    vcnt_r, vcnt_nxt;
  logic [SECTOR_W-1:0] fsec_r, fsec_nxt;
  logic [TYPE_W-1:0]   ftyp_r, ftyp_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [SECTOR_W-1:0] out_sector_r, out_sector_nxt;
  logic [TYPE_W-1:0]   out_type_r, out_type_nxt;
  logic                out_empty_r, out_empty_nxt;

  logic             out_free;
  logic [SZ_W-1:0]  size_ext;
  logic [SZ_W-1:0]  size_lim;
  logic             name_match;
  logic [EXT_W-1:0] hit_ext;
  logic [EXT_W-1:0] free_ext;

  assign out_free   = !out_valid_r || out_ready;
  assign size_ext   = SZ_W'(table_size);
  assign size_lim   = SZ_W'(MAX_ENTRIES);
  assign name_match = (st_rd_data[DATA_W-1 -: NAME_W] == name_r);
  assign hit_ext    = EXT_W'(hit_idx_r);
  assign free_ext   = EXT_W'(free_idx_r);

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_sector = out_sector_r;
  assign out_type   = out_type_r;
  assign out_empty  = out_empty_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_cnt_r == n_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt         = op_r;
    name_nxt       = name_r;
    sec_nxt        = sec_r;
    typ_nxt        = typ_r;
    n_nxt          = n_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    vcnt_nxt       = vcnt_r;
    fsec_nxt       = fsec_r;
    ftyp_nxt       = ftyp_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_sector_nxt = out_sector_r;
    out_type_nxt   = out_type_r;
    out_empty_nxt  = out_empty_r;
    st_ctrl        = '0;
    st_rd_addr     = rd_cnt_r[IDX_W-1:0];
    st_wr_addr     = hit_idx_r;
    st_wr_data     = {name_r, sec_r, typ_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          name_nxt   = in_name;
          sec_nxt    = in_sector;
          typ_nxt    = in_type;
          n_nxt      = CNT_W'((size_ext > size_lim) ? size_lim : size_ext);
          rd_cnt_nxt = '0;
          hit_nxt    = 1'b0;
          free_nxt   = 1'b0;
          vcnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        // Reads run one slot ahead of the compare.
        if (rd_cnt_r < n_r) begin
          st_ctrl.rd_en = 1'b1;
          rd_cnt_nxt    = rd_cnt_r + CNT_W'(1);
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = rd_cnt_r[IDX_W-1:0];
        end
        if (cmp_vld_r) begin
          if (st_rd_valid) begin
            vcnt_nxt = vcnt_r + CNT_W'(1);
            if (name_match && !hit_r) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = cmp_idx_r;
              fsec_nxt    = st_rd_data[TYPE_W +: SECTOR_W];
              ftyp_nxt    = st_rd_data[TYPE_W-1:0];
            end
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_slot_nxt   = '0;
          out_sector_nxt = '0;
          out_type_nxt   = '0;
          out_empty_nxt  = (vcnt_r == '0);
          unique case (op_r)
            OP_ADD: begin
              if (hit_r) begin
                out_status_nxt = ST_DUPLICATE;
              end else if (free_r) begin
                st_ctrl.wr_en = 1'b1;
                st_wr_addr    = free_idx_r;
                out_slot_nxt  = free_ext[SLOT_W-1:0];
                out_empty_nxt = 1'b0;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            OP_REMOVE: begin
              if (hit_r) begin
                st_ctrl.vclr  = 1'b1;
                out_slot_nxt  = hit_ext[SLOT_W-1:0];
                out_empty_nxt = (vcnt_r == CNT_W'(1));
              end else begin
                out_status_nxt = ST_NOT_FOUND;
              end
            end
            default: begin
              if (hit_r) begin
                out_slot_nxt   = hit_ext[SLOT_W-1:0];
                out_sector_nxt = fsec_r;
                out_type_nxt   = ftyp_r;
              end else begin
                out_status_nxt = ST_NOT_FOUND;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    name_r       <= name_nxt;
    sec_r        <= sec_nxt;
    typ_r        <= typ_nxt;
    n_r          <= n_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    vcnt_r       <= vcnt_nxt;
    fsec_r       <= fsec_nxt;
    ftyp_r       <= ftyp_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_sector_r <= out_sector_nxt;
    out_type_r   <= out_type_nxt;
    out_empty_r  <= out_empty_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/name_directory_table_core.sv =====
// Top level of the name directory table: stream channels, register port and core wiring.
//
// The block keeps a table of named entries (name of up to NAME_BYTES bytes, a
// header sector and a type) and runs one operation per input transaction:
// lookup, add or remove, chosen by in_tuser. Each input transaction yields
// exactly one result transaction on the out_ channel with a status, the slot,
// the found sector and type, and a flag that tells whether the table is empty.
// The entries sit in a synchronous memory that is read one slot per cycle. An
// operation scans the n slots in use (n = table_size, capped at MAX_ENTRIES),
// and a new transaction is taken only after the result of the last one has
// been loaded into the output register. The registered memory read and the
// single read port set the pace of the scan.
// in_tready is high whenever the block is idle, also while an earlier result
// still waits in the output register. If the receiver stalls, the finished
// operation holds before its write-back until the output register is free.
// Reset clears all valid marks at once, so the table starts empty, and sets
// table_size to 10. table_size is written over the APB-style port at byte
// address 0 and should be changed only while no operation is in flight.
`default_nettype none

module name_directory_table_core #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned NAME_BYTES  = 9
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: name_low[63:0], name_high[71:64], sector[81:72],
  // entry_type[84:82], zero[87:85]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,
  // in_tuser: opcode[1:0]
  input  wire logic [1:0]  in_tuser,
  // out_tdata: status[1:0], slot_index[5:2], found_sector[15:6],
  // found_type[18:16], table_empty[19], zero[23:20]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  import ndt_pkg::*;

  localparam int unsigned NAME_W = NAME_BYTES * 8;
  localparam int unsigned DATA_W = NAME_W + SECTOR_W + TYPE_W;
  localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);

  logic [SIZE_W-1:0]   table_size_r, table_size_nxt;
  logic                cfg_wr;
  logic                reg_sel;

  logic [NAME_W-1:0]   name_canon;
  store_ctrl_t         st_ctrl;
  logic [IDX_W-1:0]    st_rd_addr;
  logic [IDX_W-1:0]    st_wr_addr;
  logic [DATA_W-1:0]   st_wr_data;
  logic                st_rd_valid;
  logic [DATA_W-1:0]   st_rd_data;

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [SECTOR_W-1:0] res_sector;
  logic [TYPE_W-1:0]   res_type;
  logic                res_empty;

  // Register port: one register, decoded on its word address bit.
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[2] == 1'(REG_TABLE_SIZE));
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_sel ? 32'(table_size_r) : 32'd0;

  always_comb begin
    table_size_nxt = table_size_r;
    if (cfg_wr && reg_sel) begin
      table_size_nxt = cfg_pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RST;
    end else begin
      table_size_r <= table_size_nxt;
    end
  end

  ndt_canon #(
    .NAME_BYTES (NAME_BYTES)
  ) u_canon (
    .name_low   (in_tdata[63:0]),
    .name_high  (in_tdata[71:64]),
    .name_canon (name_canon)
  );

  ndt_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .DATA_W      (DATA_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (st_ctrl),
    .rd_addr  (st_rd_addr),
    .wr_addr  (st_wr_addr),
    .wr_data  (st_wr_data),
    .rd_valid (st_rd_valid),
    .rd_data  (st_rd_data)
  );

  ndt_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .NAME_W      (NAME_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser),
    .in_name     (name_canon),
    .in_sector   (in_tdata[81:72]),
    .in_type     (in_tdata[84:82]),
    .table_size  (table_size_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (res_status),
    .out_slot    (res_slot),
    .out_sector  (res_sector),
    .out_type    (res_type),
    .out_empty   (res_empty),
    .st_ctrl     (st_ctrl),
    .st_rd_addr  (st_rd_addr),
    .st_wr_addr  (st_wr_addr),
    .st_wr_data  (st_wr_data),
    .st_rd_valid (st_rd_valid),
    .st_rd_data  (st_rd_data)
  );

  assign out_tdata = {4'd0, res_empty, res_type, res_sector, res_slot, res_status};

endmodule

`default_nettype wire

// ===== test/name_directory_table_core_tb.sv =====
// Self-checking testbench for the name directory table core: directed table, then random phases.
module name_directory_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ndt_pkg::*;

  // The block is built with its default depth and name length.
  localparam int unsigned TB_DEPTH    = 16;
  localparam int unsigned TB_NAME_LEN = 9;
  // The spare opcode is not named in the package; the block treats it as a lookup.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  // The limit leaves a wide margin over the worst case of the whole run.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned POOL_NAMES  = 24;
  localparam int unsigned PHASE_ITEMS = 100;

  // One result transaction, decoded from out_tdata.
  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] sector;
    logic [TYPE_W-1:0]   etype;
    logic                empty;
  } dir_result_t;

  typedef enum bit {ROW_CFG, ROW_OP} row_kind_t;

  // A row of the directed table: either a table_size write or one operation,
  // optionally with its result typed in by hand.
  typedef struct {
    row_kind_t         kind;
    logic [31:0]       size;
    logic [OP_W-1:0]   op;
    logic [63:0]       name_lo;
    logic [7:0]        name_hi;
    logic [SECTOR_W-1:0] sector;
    logic [TYPE_W-1:0] etype;
    bit                typed;
    dir_result_t       result;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  name_directory_table_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    // in_tdata: name_low[63:0], name_high[71:64], sector[81:72], entry_type[84:82]
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    // in_tuser: opcode[1:0]
    .in_tuser    (in_tuser),
    // out_tdata: status[1:0], slot_index[5:2], found_sector[15:6],
    // found_type[18:16], table_empty[19]
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the directory contents and of the size register.
  logic [SIZE_W-1:0]   dir_size = TABLE_SIZE_RST;
  bit                  dir_valid [TB_DEPTH];
  logic [63:0]         dir_name_lo [TB_DEPTH];
  logic [7:0]          dir_name_hi [TB_DEPTH];
  logic [SECTOR_W-1:0] dir_sector [TB_DEPTH];
  logic [TYPE_W-1:0]   dir_type [TB_DEPTH];

  dir_result_t expected_results [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  // When set, neither side inserts idle cycles.
  bit          quiet = 1'b0;
  int unsigned ready_stall = 0;

  // Random name pool; names shorter than nine bytes carry their length so that
  // garbage can be planted behind the terminating zero.
  logic [63:0] pool_lo [POOL_NAMES];
  logic [7:0]  pool_hi [POOL_NAMES];
  int unsigned pool_len [POOL_NAMES];

  // A name ends at its first zero byte; everything behind it counts as zero.
  function automatic void trim_name(input logic [63:0] lo, input logic [7:0] hi,
                                    output logic [63:0] tlo, output logic [7:0] thi);
    logic [7:0] b;
    bit         ended;
    tlo = '0;
    thi = '0;
    ended = 1'b0;
    for (int i = 0; i < TB_NAME_LEN; i++) begin
      b = (i < 8) ? lo[8*i +: 8] : hi;
      if (b == 8'h00) ended = 1'b1;
      if (!ended) begin
        if (i < 8) tlo[8*i +: 8] = b;
        else thi = b;
      end
    end
  endfunction

  // Applies one operation to the mirror and returns the result it must give.
  function automatic dir_result_t directory_apply(input logic [OP_W-1:0] op,
                                                  input logic [63:0] lo,
                                                  input logic [7:0] hi,
                                                  input logic [SECTOR_W-1:0] sec,
                                                  input logic [TYPE_W-1:0] typ);
    logic [63:0] tlo;
    logic [7:0]  thi;
    int          n;
    int          hit;
    dir_result_t r;
    trim_name(lo, hi, tlo, thi);
    // Sizes above the built depth act as the full depth.
    n = (dir_size > TB_DEPTH) ? TB_DEPTH : dir_size;
    hit = -1;
    for (int i = 0; i < n; i++)
      if (hit < 0 && dir_valid[i] && dir_name_lo[i] == tlo && dir_name_hi[i] == thi)
        hit = i;
    r = '0;
    r.status = ST_OK;
    if (op == OP_ADD) begin
      // The duplicate check comes before the search for a free slot.
      if (hit >= 0) begin
        r.status = ST_DUPLICATE;
      end else begin
        r.status = ST_FULL;
        for (int i = 0; i < n; i++)
          if (r.status == ST_FULL && !dir_valid[i]) begin
            dir_valid[i]   = 1'b1;
            dir_name_lo[i] = tlo;
            dir_name_hi[i] = thi;
            dir_sector[i]  = sec;
            dir_type[i]    = typ;
            r.status = ST_OK;
            r.slot   = i[SLOT_W-1:0];
          end
      end
    end else if (op == OP_REMOVE) begin
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        dir_valid[hit] = 1'b0;
        r.slot = hit[SLOT_W-1:0];
      end
    end else begin
      // Lookup, and the spare opcode behaves the same way.
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.slot   = hit[SLOT_W-1:0];
        r.sector = dir_sector[hit];
        r.etype  = dir_type[hit];
      end
    end
    r.empty = 1'b1;
    for (int i = 0; i < n; i++)
      if (dir_valid[i]) r.empty = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t op_row(input logic [OP_W-1:0] op, input logic [63:0] lo,
                                       input logic [7:0] hi, input int sec, input int typ,
                                       input bit typed, input status_t st, input int slot,
                                       input int fsec, input int ftyp, input bit empty);
    stim_row_t row;
    row.kind    = ROW_OP;
    row.size    = '0;
    row.op      = op;
    row.name_lo = lo;
    row.name_hi = hi;
    row.sector  = sec[SECTOR_W-1:0];
    row.etype   = typ[TYPE_W-1:0];
    row.typed   = typed;
    row.result.status = st;
    row.result.slot   = slot[SLOT_W-1:0];
    row.result.sector = fsec[SECTOR_W-1:0];
    row.result.etype  = ftyp[TYPE_W-1:0];
    row.result.empty  = empty;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [31:0] size);
    stim_row_t row;
    row = op_row(OP_LOOKUP, '0, '0, 0, 0, 1'b0, ST_OK, 0, 0, 0, 1'b0);
    row.kind = ROW_CFG;
    row.size = size;
    return row;
  endfunction

  // Drives one operation and waits until the block takes it. tvalid is left
  // high after the transaction so that a following operation can go out
  // back to back; callers lower it with drop_input when the stream pauses.
  task automatic issue_op(input logic [OP_W-1:0] op, input logic [63:0] lo,
                          input logic [7:0] hi, input logic [SECTOR_W-1:0] sec,
                          input logic [TYPE_W-1:0] typ, input bit typed,
                          input dir_result_t typed_result);
    dir_result_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, typ, sec, hi, lo};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    // The mirror always advances; a hand-typed result replaces the predicted one.
    predicted = directory_apply(op, lo, hi, sec, typ);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic drop_input();
    in_tvalid <= 1'b0;
  endtask

  // Every result has a matching input, so once the queue is empty and the
  // slack wait has run out, no operation is left in flight.
  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // Writes table_size while the block is idle, then reads it back.
  task automatic write_table_size(input logic [31:0] value);
    drop_input();
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(REG_TABLE_SIZE * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    dir_size = value[SIZE_W-1:0];
    // Go straight from the write access into the setup cycle of the read.
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[SIZE_W-1:0] !== dir_size) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table_size readback: expected %0d, got %0d", dir_size,
                 cfg_prdata[SIZE_W-1:0]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Result side: random stall bursts on out_tready and the in-order check of
  // every result transaction against the oldest expectation.
  always @(posedge clk) begin
    dir_result_t got;
    dir_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tdata[1:0]);
      got.slot   = out_tdata[5:2];
      got.sector = out_tdata[15:6];
      got.etype  = out_tdata[18:16];
      got.empty  = out_tdata[19];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d sector %0d type %0d empty %0d",
                   got.status, got.slot, got.sector, got.etype, got.empty);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("result mismatch: expected status %0d slot %0d sector %0d type %0d",
                   want.status, want.slot, want.sector, want.etype);
            $display(" empty %0d, got status %0d slot %0d sector %0d type %0d empty %0d",
                     want.empty, got.status, got.slot, got.sector, got.etype, got.empty);
          end
        end
      end
    end
    if (ready_stall != 0) begin
      ready_stall <= ready_stall - 1;
      out_tready  <= (ready_stall == 1);
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_tready  <= 1'b0;
      ready_stall <= $urandom_range(1, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [31:0]         phase_sizes [13];
    logic [OP_W-1:0]     op;
    logic [63:0]         lo;
    logic [7:0]          hi;
    logic [31:0]         size_word;
    int unsigned         pick;
    int unsigned         span;
    int unsigned         k;
    stim_row_t           row;

    phase_sizes = '{16, 1, 4, 0, 31, 17, 2, 8, 3, 16, 5, 10, 6};

    for (int i = 0; i < TB_DEPTH; i++) begin
      dir_valid[i]   = 1'b0;
      dir_name_lo[i] = '0;
      dir_name_hi[i] = '0;
      dir_sector[i]  = '0;
      dir_type[i]    = '0;
    end

    // Random names of 0 to 9 nonzero bytes, zero padded.
    for (int p = 0; p < POOL_NAMES; p++) begin
      pool_len[p] = $urandom_range(0, TB_NAME_LEN);
      pool_lo[p] = '0;
      pool_hi[p] = '0;
      for (int b = 0; b < pool_len[p]; b++)
        if (b < 8) pool_lo[p][8*b +: 8] = 8'($urandom_range(1, 255));
        else pool_hi[p] = 8'($urandom_range(1, 255));
    end

    // Directed table. The block comes out of reset with ten slots in use and
    // an empty table. Names are short ASCII letters, the all-ones nine-byte
    // name, its eight-byte cousin and the empty name.
    directed_rows.push_back(op_row(OP_LOOKUP, 64'h41, 8'h00, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 1));
    directed_rows.push_back(op_row(OP_ADD, 64'h41, 8'h00, 1023, 7, 1, ST_OK, 0, 0, 0, 0));
    directed_rows.push_back(op_row(OP_LOOKUP, 64'h41, 8'h00, 0, 0, 1, ST_OK, 0, 1023, 7, 0));
    // Garbage behind the terminating zero must not make the name different.
    directed_rows.push_back(op_row(OP_ADD, 64'hFFFF_FFFF_FFFF_0041, 8'hFF, 3, 1,
                                   1, ST_DUPLICATE, 0, 0, 0, 0));
    directed_rows.push_back(op_row(OP_ADD, '1, 8'hFF, 0, 0, 1, ST_OK, 1, 0, 0, 0));
    directed_rows.push_back(op_row(OP_LOOKUP, '1, 8'hFF, 0, 0, 1, ST_OK, 1, 0, 0, 0));
    directed_rows.push_back(op_row(OP_ADD, '1, 8'h00, 512, 2, 1, ST_OK, 2, 0, 0, 0));
    directed_rows.push_back(op_row(OP_ADD, 64'h0, 8'h00, 5, 3, 1, ST_OK, 3, 0, 0, 0));
    // A leading zero byte makes this the empty name, whatever byte 8 holds.
    directed_rows.push_back(op_row(OP_LOOKUP, 64'h0, 8'hAB, 0, 0, 1, ST_OK, 3, 5, 3, 0));
    directed_rows.push_back(op_row(OP_SPARE, 64'h41, 8'h00, 0, 0, 1, ST_OK, 0, 1023, 7, 0));
    directed_rows.push_back(op_row(OP_REMOVE, 64'h41, 8'h00, 0, 0, 1, ST_OK, 0, 0, 0, 0));
    // The freed slot 0 is the lowest free one again.
    directed_rows.push_back(op_row(OP_ADD, 64'h42, 8'h00, 682, 5, 1, ST_OK, 0, 0, 0, 0));
    directed_rows.push_back(op_row(OP_REMOVE, 64'h00FF_FF00, 8'h12, 0, 0, 1, ST_OK, 3, 0, 0, 0));
    directed_rows.push_back(op_row(OP_REMOVE, '1, 8'hFF, 0, 0, 1, ST_OK, 1, 0, 0, 0));
    directed_rows.push_back(op_row(OP_REMOVE, '1, 8'h00, 0, 0, 1, ST_OK, 2, 0, 0, 0));
    directed_rows.push_back(op_row(OP_LOOKUP, 64'h42, 8'h00, 0, 0, 0, ST_OK, 0, 0, 0, 0));
    directed_rows.push_back(op_row(OP_REMOVE, 64'h42, 8'h00, 0, 0, 1, ST_OK, 0, 0, 0, 1));
    // Two slots: fill them, then a full table and a duplicate on a full table.
    directed_rows.push_back(cfg_row(32'd2));
    directed_rows.push_back(op_row(OP_ADD, 64'h43, 8'h00, 100, 4, 1, ST_OK, 0, 0, 0, 0));
    directed_rows.push_back(op_row(OP_ADD, 64'h44, 8'h00, 200, 6, 1, ST_OK, 1, 0, 0, 0));
    directed_rows.push_back(op_row(OP_ADD, 64'h45, 8'h00, 9, 1, 1, ST_FULL, 0, 0, 0, 0));
    directed_rows.push_back(op_row(OP_ADD, 64'h43, 8'h00, 9, 1, 1, ST_DUPLICATE, 0, 0, 0, 0));
    // One slot: the entry in slot 1 lies beyond the size and is not seen.
    directed_rows.push_back(cfg_row(32'd1));
    directed_rows.push_back(op_row(OP_LOOKUP, 64'h44, 8'h00, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0));
    // No slot at all: nothing is found, nothing fits, the table reads empty.
    directed_rows.push_back(cfg_row(32'd0));
    directed_rows.push_back(op_row(OP_LOOKUP, 64'h43, 8'h00, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 1));
    directed_rows.push_back(op_row(OP_ADD, 64'h45, 8'h00, 9, 1, 1, ST_FULL, 0, 0, 0, 1));
    // Full depth: the hidden entry comes back with its contents.
    directed_rows.push_back(cfg_row(32'd16));
    directed_rows.push_back(op_row(OP_LOOKUP, 64'h44, 8'h00, 0, 0, 0, ST_OK, 0, 0, 0, 0));
    directed_rows.push_back(op_row(OP_REMOVE, 64'h43, 8'h00, 0, 0, 1, ST_OK, 0, 0, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG)
        write_table_size(row.size);
      else
        issue_op(row.op, row.name_lo, row.name_hi, row.sector, row.etype, row.typed, row.result);
    end

    // Random phases, one table size each. Names mostly come from the first
    // 2*size+2 pool names (at most the pool), so duplicates, hits and full
    // tables are frequent; the last phase runs without any idle cycles.
    foreach (phase_sizes[ph]) begin
      size_word = phase_sizes[ph];
      if ($urandom_range(0, 1) == 1)
        size_word = ($urandom() & ~32'h1F) | size_word;
      write_table_size(size_word);
      if (ph == $size(phase_sizes) - 1) quiet = 1'b1;
      span = 2 * phase_sizes[ph] + 2;
      if (span > POOL_NAMES) span = POOL_NAMES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) op = OP_ADD;
        else if (pick < 75) op = OP_LOOKUP;
        else if (pick < 95) op = OP_REMOVE;
        else op = OP_SPARE;
        if ($urandom_range(0, 6) == 0) begin
          lo = {$urandom(), $urandom()};
          hi = 8'($urandom());
        end else begin
          k  = $urandom_range(0, span - 1);
          lo = pool_lo[k];
          hi = pool_hi[k];
          // Half of the time, random bytes follow the terminating zero.
          if ($urandom_range(0, 1) == 1)
            for (int b = pool_len[k] + 1; b < TB_NAME_LEN; b++)
              if (b < 8) lo[8*b +: 8] = 8'($urandom());
              else hi = 8'($urandom());
        end
        issue_op(op, lo, hi, SECTOR_W'($urandom()), TYPE_W'($urandom()), 1'b0, '0);
      end
    end

    drop_input();
    wait_drained();
    mismatches += expected_results.size();
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ndt_pkg.sv
rtl/core/ndt_canon.sv
rtl/core/ndt_store.sv
rtl/core/ndt_ctrl.sv
rtl/core/name_directory_table_core.sv
test/name_directory_table_core_tb.sv
